// ===== src/nfa_pkg.sv =====
package nfa_pkg;

  localparam int ADDR_W  = 14;
  localparam int BYTES_W = 24;
  localparam int COPY_W  = 18;
  localparam int MODE_W  = 2;

  // Wide enough for every compare on byte counts, cell counts and cell indexes
  localparam int CW = 26;

  localparam int UNIT_BYTES = 16;
  localparam int UNIT_SHIFT = 4;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BYTES_W-1:0] byte_count;
    logic [ADDR_W-1:0]  block_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic              failed;
    logic [COPY_W-1:0] copy_bytes;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_DISP,
    ST_RZ_RD,
    ST_RZ_CHK,
    ST_A_START,
    ST_A_RD,
    ST_A_CHK,
    ST_A_TRD,
    ST_A_TWR,
    ST_A_GROW,
    ST_A_END,
    ST_R_RD,
    ST_R_CHK,
    ST_R_BRD,
    ST_R_QRD,
    ST_R_WBP,
    ST_R_WP,
    ST_DONE
  } state_t;

endpackage

// ===== src/nfa_hdr_ram.sv =====
module nfa_hdr_ram #(
  parameter int DEPTH = 16384,
  parameter int DW    = 29
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/nfa_ctrl.sv =====
module nfa_ctrl #(
  parameter int ARENA_UNITS = 16384,
  parameter int MIN_GROW    = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  nfa_pkg::in_item_t                      in_data,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output nfa_pkg::out_item_t                     res_data,
  output logic                                   ram_re,
  output logic [$clog2(ARENA_UNITS)-1:0]         ram_raddr,
  output logic                                   ram_we,
  output logic [$clog2(ARENA_UNITS)-1:0]         ram_waddr,
  output logic [2*$clog2(ARENA_UNITS):0]         ram_wdata,
  input  logic [2*$clog2(ARENA_UNITS):0]         ram_rdata
);

  localparam int IW     = $clog2(ARENA_UNITS);
  localparam int AW     = IW + 1;
  localparam int CW     = nfa_pkg::CW;
  localparam int ADDR_W = nfa_pkg::ADDR_W;
  localparam int COPY_W = nfa_pkg::COPY_W;
  localparam int BYTES_W = nfa_pkg::BYTES_W;
  localparam int CAP    = 4 * ARENA_UNITS + 8;
  localparam int SW     = $clog2(CAP + 1);

  nfa_pkg::state_t state_r, state_nxt;

  logic                    list_ready_r, list_ready_nxt;
  logic [IW-1:0]           rover_r, rover_nxt;
  logic [AW-1:0]           brk_r, brk_nxt;

  logic [1:0]              mode_r, mode_nxt;
  logic [BYTES_W-1:0]      nbytes_r, nbytes_nxt;
  logic [ADDR_W-1:0]       blk_r, blk_nxt;
  logic [AW-1:0]           nu_r, nu_nxt;
  logic [IW-1:0]           p_r, p_nxt;
  logic [IW-1:0]           prev_r, prev_nxt;
  logic [AW-1:0]           prev_size_r, prev_size_nxt;
  logic                    skip_r, skip_nxt;
  logic                    cnt_r, cnt_nxt;
  logic [SW-1:0]           a_steps_r, a_steps_nxt;
  logic [IW-1:0]           tail_r, tail_nxt;
  logic [ADDR_W-1:0]       res_r, res_nxt;
  logic                    fail_r, fail_nxt;
  logic [COPY_W-1:0]       copy_r, copy_nxt;
  logic [CW-1:0]           cur_r, cur_nxt;
  logic                    move_r, move_nxt;
  logic [IW-1:0]           bp_r, bp_nxt;
  logic                    ret_grow_r, ret_grow_nxt;
  logic [IW-1:0]           rp_r, rp_nxt;
  logic [IW-1:0]           rq_r, rq_nxt;
  logic [AW-1:0]           rpsize_r, rpsize_nxt;
  logic [AW-1:0]           bpsize_r, bpsize_nxt;
  logic [IW-1:0]           nbn_r, nbn_nxt;
  logic [AW-1:0]           nbs_r, nbs_nxt;
  logic [SW-1:0]           r_steps_r, r_steps_nxt;

  logic [IW-1:0] rd_next;
  logic [AW-1:0] rd_size;
  logic [CW-1:0] nu_calc, tail_c, grow_c, cur_c;
  logic [AW-1:0] rest;
  logic [IW-1:0] bp_in;
  logic          nu_big, addr_ok, a_fit, a_eq, tail_bad, grow_bad;
  logic          r_stop, merge_q, merge_p, rz_fits;

  assign rd_next = ram_rdata[2*IW:AW];
  assign rd_size = ram_rdata[AW-1:0];

  assign nu_calc = ((CW'(nbytes_r) + CW'(nfa_pkg::UNIT_BYTES - 1)) >> nfa_pkg::UNIT_SHIFT)
                   + CW'(1);
  assign nu_big  = nu_calc >= CW'(ARENA_UNITS);
  assign addr_ok = (CW'(blk_r) >= CW'(2)) && (CW'(blk_r) <= CW'(brk_r)) &&
                   (CW'(blk_r) - CW'(1) < CW'(ARENA_UNITS));
  assign bp_in   = IW'(CW'(blk_r) - CW'(1));

  assign a_fit    = CW'(rd_size) >= CW'(nu_r);
  assign a_eq     = rd_size == nu_r;
  assign rest     = rd_size - nu_r;
  assign tail_c   = CW'(p_r) + CW'(rest);
  assign tail_bad = tail_c + CW'(1) >= CW'(ARENA_UNITS);
  assign grow_c   = (CW'(nu_r) < CW'(MIN_GROW)) ? CW'(MIN_GROW) : CW'(nu_r);
  assign grow_bad = grow_c > CW'(ARENA_UNITS) - CW'(brk_r);

  // Stop the walk where bp falls between p and its successor, wrap included
  assign r_stop = ((bp_r > rp_r) && (bp_r < rd_next)) ||
                  ((rp_r >= rd_next) && ((bp_r > rp_r) || (bp_r < rd_next)));
  assign merge_q = CW'(bp_r) + CW'(bpsize_r) == CW'(rq_r);
  assign merge_p = CW'(rp_r) + CW'(rpsize_r) == CW'(bp_r);

  assign cur_c   = (rd_size == '0) ? '0 :
                   (CW'(rd_size) - CW'(1)) << nfa_pkg::UNIT_SHIFT;
  assign rz_fits = CW'(nbytes_r) <= cur_c;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.mode != nfa_pkg::MODE_ALLOC && in_data.mode != nfa_pkg::MODE_FREE &&
              in_data.mode != nfa_pkg::MODE_RESIZE) begin
            state_nxt = nfa_pkg::ST_DONE;
          end else if (!list_ready_r) begin
            state_nxt = nfa_pkg::ST_INIT;
          end else begin
            state_nxt = nfa_pkg::ST_DISP;
          end
        end
      end
      nfa_pkg::ST_INIT: state_nxt = nfa_pkg::ST_DISP;
      nfa_pkg::ST_DISP: begin
        unique case (mode_r)
          nfa_pkg::MODE_ALLOC: state_nxt = nfa_pkg::ST_A_START;
          nfa_pkg::MODE_FREE:  state_nxt = addr_ok ? nfa_pkg::ST_R_RD : nfa_pkg::ST_DONE;
          nfa_pkg::MODE_RESIZE: begin
            if (!addr_ok) begin
              state_nxt = (nbytes_r != '0) ? nfa_pkg::ST_A_START : nfa_pkg::ST_DONE;
            end else if (nbytes_r == '0) begin
              state_nxt = nfa_pkg::ST_R_RD;
            end else begin
              state_nxt = nfa_pkg::ST_RZ_RD;
            end
          end
          default: state_nxt = nfa_pkg::ST_DONE;
        endcase
      end
      nfa_pkg::ST_RZ_RD:   state_nxt = nfa_pkg::ST_RZ_CHK;
      nfa_pkg::ST_RZ_CHK:  state_nxt = rz_fits ? nfa_pkg::ST_DONE : nfa_pkg::ST_A_START;
      nfa_pkg::ST_A_START: state_nxt = nu_big ? nfa_pkg::ST_A_END : nfa_pkg::ST_A_RD;
      nfa_pkg::ST_A_RD:    state_nxt = nfa_pkg::ST_A_CHK;
      nfa_pkg::ST_A_CHK: begin
        if (!skip_r && a_fit) begin
          state_nxt = (a_eq || tail_bad) ? nfa_pkg::ST_A_END : nfa_pkg::ST_A_TRD;
        end else if (!skip_r && p_r == rover_r) begin
          state_nxt = nfa_pkg::ST_A_GROW;
        end else if (cnt_r && a_steps_r >= SW'(CAP)) begin
          state_nxt = nfa_pkg::ST_A_END;
        end else begin
          state_nxt = nfa_pkg::ST_A_RD;
        end
      end
      nfa_pkg::ST_A_TRD:  state_nxt = nfa_pkg::ST_A_TWR;
      nfa_pkg::ST_A_TWR:  state_nxt = nfa_pkg::ST_A_END;
      nfa_pkg::ST_A_GROW: state_nxt = grow_bad ? nfa_pkg::ST_A_END : nfa_pkg::ST_R_RD;
      nfa_pkg::ST_A_END:  state_nxt = (res_r != '0 && move_r) ? nfa_pkg::ST_R_RD :
                                                                nfa_pkg::ST_DONE;
      nfa_pkg::ST_R_RD:   state_nxt = nfa_pkg::ST_R_CHK;
      nfa_pkg::ST_R_CHK: begin
        if (r_stop) begin
          state_nxt = nfa_pkg::ST_R_BRD;
        end else if (r_steps_r >= SW'(CAP)) begin
          state_nxt = ret_grow_r ? nfa_pkg::ST_A_RD : nfa_pkg::ST_DONE;
        end else begin
          state_nxt = nfa_pkg::ST_R_RD;
        end
      end
      nfa_pkg::ST_R_BRD: state_nxt = nfa_pkg::ST_R_QRD;
      nfa_pkg::ST_R_QRD: state_nxt = nfa_pkg::ST_R_WBP;
      nfa_pkg::ST_R_WBP: state_nxt = nfa_pkg::ST_R_WP;
      nfa_pkg::ST_R_WP:  state_nxt = ret_grow_r ? nfa_pkg::ST_A_RD : nfa_pkg::ST_DONE;
      nfa_pkg::ST_DONE:  state_nxt = res_ready ? nfa_pkg::ST_IDLE : nfa_pkg::ST_DONE;
      default:           state_nxt = nfa_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and header store port
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state_r)
      nfa_pkg::ST_IDLE: in_ready = 1'b1;
      nfa_pkg::ST_INIT: begin
        ram_we = 1'b1;
      end
      nfa_pkg::ST_RZ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = bp_in;
      end
      nfa_pkg::ST_A_RD: begin
        ram_re    = 1'b1;
        ram_raddr = p_r;
      end
      nfa_pkg::ST_A_CHK: begin
        if (!skip_r && a_fit) begin
          if (a_eq) begin
            ram_we    = 1'b1;
            ram_waddr = prev_r;
            ram_wdata = {rd_next, prev_size_r};
          end else if (!tail_bad) begin
            ram_we    = 1'b1;
            ram_waddr = p_r;
            ram_wdata = {rd_next, rest};
          end
        end
      end
      nfa_pkg::ST_A_TRD: begin
        ram_re    = 1'b1;
        ram_raddr = tail_r;
      end
      nfa_pkg::ST_A_TWR: begin
        ram_we    = 1'b1;
        ram_waddr = tail_r;
        ram_wdata = {rd_next, nu_r};
      end
      nfa_pkg::ST_A_GROW: begin
        if (!grow_bad) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(brk_r);
          ram_wdata = {{IW{1'b0}}, AW'(grow_c)};
        end
      end
      nfa_pkg::ST_R_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rp_r;
      end
      nfa_pkg::ST_R_BRD: begin
        ram_re    = 1'b1;
        ram_raddr = bp_r;
      end
      nfa_pkg::ST_R_QRD: begin
        ram_re    = 1'b1;
        ram_raddr = rq_r;
      end
      nfa_pkg::ST_R_WBP: begin
        ram_we    = 1'b1;
        ram_waddr = bp_r;
        ram_wdata = merge_q ? {rd_next, bpsize_r + rd_size} : {rq_r, bpsize_r};
      end
      nfa_pkg::ST_R_WP: begin
        ram_we    = 1'b1;
        ram_waddr = rp_r;
        ram_wdata = merge_p ? {nbn_r, rpsize_r + nbs_r} : {bp_r, rpsize_r};
      end
      nfa_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res_data.result_addr = res_r;
  assign res_data.failed      = fail_r;
  assign res_data.copy_bytes  = copy_r;

  // Datapath next values
  always_comb begin
    list_ready_nxt = list_ready_r;
    rover_nxt      = rover_r;
    brk_nxt        = brk_r;
    mode_nxt       = mode_r;
    nbytes_nxt     = nbytes_r;
    blk_nxt        = blk_r;
    nu_nxt         = nu_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    prev_size_nxt  = prev_size_r;
    skip_nxt       = skip_r;
    cnt_nxt        = cnt_r;
    a_steps_nxt    = a_steps_r;
    tail_nxt       = tail_r;
    res_nxt        = res_r;
    fail_nxt       = fail_r;
    copy_nxt       = copy_r;
    cur_nxt        = cur_r;
    move_nxt       = move_r;
    bp_nxt         = bp_r;
    ret_grow_nxt   = ret_grow_r;
    rp_nxt         = rp_r;
    rq_nxt         = rq_r;
    rpsize_nxt     = rpsize_r;
    bpsize_nxt     = bpsize_r;
    nbn_nxt        = nbn_r;
    nbs_nxt        = nbs_r;
    r_steps_nxt    = r_steps_r;
    unique case (state_r)
      nfa_pkg::ST_IDLE: begin
        mode_nxt   = in_data.mode;
        nbytes_nxt = in_data.byte_count;
        blk_nxt    = in_data.block_addr;
        res_nxt    = '0;
        fail_nxt   = 1'b0;
        copy_nxt   = '0;
        move_nxt   = 1'b0;
      end
      nfa_pkg::ST_INIT: begin
        rover_nxt      = '0;
        list_ready_nxt = 1'b1;
      end
      nfa_pkg::ST_DISP: begin
        bp_nxt       = bp_in;
        ret_grow_nxt = 1'b0;
        rp_nxt       = rover_r;
        r_steps_nxt  = '0;
      end
      nfa_pkg::ST_RZ_CHK: begin
        if (rz_fits) begin
          res_nxt = blk_r;
        end else begin
          cur_nxt  = cur_c;
          move_nxt = 1'b1;
        end
      end
      nfa_pkg::ST_A_START: begin
        nu_nxt      = AW'(nu_calc);
        p_nxt       = rover_r;
        skip_nxt    = 1'b1;
        cnt_nxt     = 1'b0;
        a_steps_nxt = '0;
      end
      nfa_pkg::ST_A_CHK: begin
        if (!skip_r && a_fit) begin
          if (a_eq) begin
            rover_nxt = prev_r;
            res_nxt   = ADDR_W'(CW'(p_r) + CW'(1));
          end else if (!tail_bad) begin
            rover_nxt = prev_r;
            tail_nxt  = IW'(tail_c);
            res_nxt   = ADDR_W'(tail_c + CW'(1));
          end
        end else if (!skip_r && p_r == rover_r) begin
          // grow handled in its own state
        end else if (!(cnt_r && a_steps_r >= SW'(CAP))) begin
          prev_nxt      = p_r;
          prev_size_nxt = rd_size;
          p_nxt         = rd_next;
          a_steps_nxt   = a_steps_r + SW'(cnt_r);
          skip_nxt      = 1'b0;
          cnt_nxt       = 1'b1;
        end
      end
      nfa_pkg::ST_A_GROW: begin
        if (!grow_bad) begin
          bp_nxt       = IW'(brk_r);
          brk_nxt      = AW'(CW'(brk_r) + grow_c);
          ret_grow_nxt = 1'b1;
          rp_nxt       = rover_r;
          r_steps_nxt  = '0;
        end
      end
      nfa_pkg::ST_A_END: begin
        fail_nxt = res_r == '0;
        if (res_r != '0 && move_r) begin
          copy_nxt     = COPY_W'(cur_r);
          bp_nxt       = bp_in;
          ret_grow_nxt = 1'b0;
          rp_nxt       = rover_r;
          r_steps_nxt  = '0;
        end
      end
      nfa_pkg::ST_R_CHK: begin
        if (r_stop) begin
          rq_nxt     = rd_next;
          rpsize_nxt = rd_size;
        end else if (r_steps_r >= SW'(CAP)) begin
          // abandon the walk; back to the search from the unchanged rover
          p_nxt    = rover_r;
          skip_nxt = 1'b1;
          cnt_nxt  = 1'b1;
        end else begin
          rp_nxt      = rd_next;
          r_steps_nxt = r_steps_r + SW'(1);
        end
      end
      nfa_pkg::ST_R_QRD: bpsize_nxt = rd_size;
      nfa_pkg::ST_R_WBP: begin
        nbn_nxt = merge_q ? rd_next : rq_r;
        nbs_nxt = merge_q ? bpsize_r + rd_size : bpsize_r;
      end
      nfa_pkg::ST_R_WP: begin
        rover_nxt = rp_r;
        p_nxt     = rp_r;
        skip_nxt  = 1'b1;
        cnt_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nfa_pkg::ST_IDLE;
      list_ready_r <= 1'b0;
      rover_r      <= '0;
      brk_r        <= AW'(1);
    end else begin
      state_r      <= state_nxt;
      list_ready_r <= list_ready_nxt;
      rover_r      <= rover_nxt;
      brk_r        <= brk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    nbytes_r    <= nbytes_nxt;
    blk_r       <= blk_nxt;
    nu_r        <= nu_nxt;
    p_r         <= p_nxt;
    prev_r      <= prev_nxt;
    prev_size_r <= prev_size_nxt;
    skip_r      <= skip_nxt;
    cnt_r       <= cnt_nxt;
    a_steps_r   <= a_steps_nxt;
    tail_r      <= tail_nxt;
    res_r       <= res_nxt;
    fail_r      <= fail_nxt;
    copy_r      <= copy_nxt;
    cur_r       <= cur_nxt;
    move_r      <= move_nxt;
    bp_r        <= bp_nxt;
    ret_grow_r  <= ret_grow_nxt;
    rp_r        <= rp_nxt;
    rq_r        <= rq_nxt;
    rpsize_r    <= rpsize_nxt;
    bpsize_r    <= bpsize_nxt;
    nbn_r       <= nbn_nxt;
    nbs_r       <= nbs_nxt;
    r_steps_r   <= r_steps_nxt;
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != nfa_pkg::ST_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_brk_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> brk_r >= $past(brk_r))
    else $error("break index moved backwards");

  a_brk_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(brk_r) <= CW'(ARENA_UNITS))
    else $error("break index beyond arena");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("header read and write at one address");

endmodule

// ===== src/next_fit_free_list_allocator_top.sv =====
// Each walk step reads one free-list header; a heap grow adds a
// second list walk, which frees the new cells, before the search resumes.
// Throughput: one item at a time; the single header store read in each walk
// step sets the pace. A result waits in an output register while the next item enters.
// Reset: synchronous active low; the free list is set up on the first item, the
// header store needs no clearing pass.
module next_fit_free_list_allocator_top #(
  parameter int ARENA_UNITS = 16384,
  parameter int MIN_GROW    = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nfa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nfa_pkg::out_item_t  out_data
);

  localparam int IW = $clog2(ARENA_UNITS);
  localparam int DW = 2 * IW + 1;

  logic               res_valid, res_ready;
  nfa_pkg::out_item_t res_data;
  logic               ram_re, ram_we;
  logic [IW-1:0]      ram_raddr, ram_waddr;
  logic [DW-1:0]      ram_wdata, ram_rdata;

  logic               out_valid_r, out_valid_nxt;
  nfa_pkg::out_item_t out_data_r;

  nfa_ctrl #(
    .ARENA_UNITS (ARENA_UNITS),
    .MIN_GROW    (MIN_GROW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  nfa_hdr_ram #(
    .DEPTH (ARENA_UNITS),
    .DW    (DW)
  ) u_hdr_ram (
    .clk   (clk),
    .re    (ram_re),
    .raddr (ram_raddr),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Take a result whenever the output register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
